// ===== rtl/core/mexp_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mexp_pkg: shared types and constants for the modular exponentiation core
// Holds the field widths, the register map, the sequencer state type and the
// status record that the shared modular multiplier reports to the sequencer.
// ----------------------------------------------------------------------------
package mexp_pkg;

  // Fixed field widths of the stream and register interfaces.
  localparam int unsigned DATA_W        = 64;
  localparam int unsigned IN_TDATA_W    = 2 * DATA_W;
  localparam int unsigned OUT_TDATA_W   = DATA_W;
  localparam int unsigned OUT_TUSER_W   = 1;

  // Default operand width; the core accepts 8 to 64.
  localparam int unsigned OPERAND_WIDTH_DEF = 64;

  // APB map: one 64-bit register per 8-byte slot, the slot index in paddr[3].
  localparam int unsigned APB_ADDR_W = 4;
  localparam int unsigned APB_DATA_W = 64;
  localparam logic        REG_MODULUS = 1'b0;

  // Sequencer states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_REDUCE,
    ST_SCAN,
    ST_SQUARE,
    ST_MULT,
    ST_DONE
  } mexp_state_e;

  // Status of the shared modular multiplier.
  typedef struct packed {
    logic busy;  // an operation is in progress
    logic done;  // one-cycle pulse, the product is valid
  } mexp_mul_stat_t;

endpackage

// ===== rtl/core/mexp_modmul.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mexp_modmul: bit-serial modular multiplier
// Computes (a * b) mod m by shift-and-add, one bit of a per cycle from the
// top bit down, keeping the accumulator reduced below m at every step.
// ----------------------------------------------------------------------------
module mexp_modmul #(
  parameter int unsigned OPERAND_WIDTH = mexp_pkg::OPERAND_WIDTH_DEF
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic [OPERAND_WIDTH-1:0]   a_i,
  input  logic [OPERAND_WIDTH-1:0]   b_i,
  input  logic [OPERAND_WIDTH-1:0]   m_i,
  output logic [OPERAND_WIDTH-1:0]   prod_o,
  output mexp_pkg::mexp_mul_stat_t   stat_o
);

  localparam int unsigned W    = OPERAND_WIDTH;
  localparam int unsigned CntW = $clog2(W);

  // (x + y) mod m for x, y below m: one add, one subtract whose sign decides.
  function automatic logic [W-1:0] add_mod(input logic [W-1:0] x,
                                           input logic [W-1:0] y,
                                           input logic [W-1:0] m);
    logic [W:0] sum;
    logic [W:0] diff;
    begin
      sum  = {1'b0, x} + {1'b0, y};
      diff = sum - {1'b0, m};
      add_mod = diff[W] ? sum[W-1:0] : diff[W-1:0];
    end
  endfunction

  logic            busy_q, busy_d;
  logic            done_q, done_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic [W-1:0]    a_q, a_d;
  logic [W-1:0]    b_q, b_d;
  logic [W-1:0]    m_q, m_d;
  logic [W-1:0]    acc_q, acc_d;
  logic [W-1:0]    dbl;

  // One step: double the accumulator, then add b when the current bit of a is set.
  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    a_d    = a_q;
    b_d    = b_q;
    m_d    = m_q;
    acc_d  = acc_q;
    dbl    = add_mod(acc_q, acc_q, m_q);
    if (start_i && !busy_q) begin
      busy_d = 1'b1;
      cnt_d  = CntW'(W - 1);
      a_d    = a_i;
      b_d    = b_i;
      m_d    = m_i;
      acc_d  = '0;
    end else if (busy_q) begin
      acc_d = a_q[W-1] ? add_mod(dbl, b_q, m_q) : dbl;
      a_d   = a_q << 1;
      cnt_d = cnt_q - CntW'(1);
      if (cnt_q == '0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  // Operand and accumulator registers.
  always_ff @(posedge clk_i) begin
    a_q   <= a_d;
    b_q   <= b_d;
    m_q   <= m_d;
    acc_q <= acc_d;
  end

  assign prod_o      = acc_q;
  assign stat_o.busy = busy_q;
  assign stat_o.done = done_q;

endmodule

// ===== rtl/core/mexp_seq.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mexp_seq: exponent scanning sequencer
// Reduces the base, then walks the exponent from the top bit down, issuing
// squarings and, per one bit, a multiply by the base to the shared modular multiplier.
// ----------------------------------------------------------------------------
module mexp_seq #(
  parameter int unsigned OPERAND_WIDTH = mexp_pkg::OPERAND_WIDTH_DEF
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  // Item entry
  input  logic                       start_i,
  input  logic [OPERAND_WIDTH-1:0]   base_i,
  input  logic [OPERAND_WIDTH-1:0]   exp_i,
  input  logic [OPERAND_WIDTH-1:0]   mod_i,
  output logic                       ready_o,
  // Result hand-off
  output logic                       res_valid_o,
  input  logic                       res_ready_i,
  output logic [OPERAND_WIDTH-1:0]   res_o,
  output logic                       err_o,
  // Shared multiplier
  output logic                       mul_start_o,
  output logic [OPERAND_WIDTH-1:0]   mul_a_o,
  output logic [OPERAND_WIDTH-1:0]   mul_b_o,
  output logic [OPERAND_WIDTH-1:0]   mul_m_o,
  input  logic [OPERAND_WIDTH-1:0]   mul_prod_i,
  input  mexp_pkg::mexp_mul_stat_t   mul_stat_i
);

  localparam int unsigned W    = OPERAND_WIDTH;
  localparam int unsigned CntW = $clog2(W);

  mexp_pkg::mexp_state_e state_q, state_d;
  logic [W-1:0]    base_q, base_d;
  logic [W-1:0]    exp_q, exp_d;
  logic [W-1:0]    mod_q, mod_d;
  logic [W-1:0]    acc_q, acc_d;
  logic            err_q, err_d;
  logic            started_q, started_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic [W-1:0]    one_in;
  logic            cur_bit;
  logic            last_bit;

  // 1 mod m for the incoming modulus: zero when m is one.
  assign one_in   = (mod_i == W'(1)) ? '0 : W'(1);
  assign cur_bit  = exp_q[W-1];
  assign last_bit = (cnt_q == '0);

  // Next state and multiplier requests.
  always_comb begin
    state_d     = state_q;
    base_d      = base_q;
    exp_d       = exp_q;
    mod_d       = mod_q;
    acc_d       = acc_q;
    err_d       = err_q;
    started_d   = started_q;
    cnt_d       = cnt_q;
    mul_start_o = 1'b0;
    mul_a_o     = acc_q;
    mul_b_o     = acc_q;
    mul_m_o     = mod_q;
    unique case (state_q)
      mexp_pkg::ST_IDLE: begin
        if (start_i) begin
          exp_d     = exp_i;
          mod_d     = mod_i;
          started_d = 1'b0;
          cnt_d     = CntW'(W - 1);
          if (mod_i == '0) begin
            acc_d   = '0;
            err_d   = 1'b1;
            state_d = mexp_pkg::ST_DONE;
          end else begin
            // Base reduction as base * (1 mod m) mod m.
            acc_d       = one_in;
            err_d       = 1'b0;
            mul_start_o = 1'b1;
            mul_a_o     = base_i;
            mul_b_o     = one_in;
            mul_m_o     = mod_i;
            state_d     = mexp_pkg::ST_REDUCE;
          end
        end
      end
      mexp_pkg::ST_REDUCE: begin
        if (mul_stat_i.done) begin
          base_d  = mul_prod_i;
          state_d = mexp_pkg::ST_SCAN;
        end
      end
      mexp_pkg::ST_SCAN: begin
        if (started_q) begin
          mul_start_o = 1'b1;
          state_d     = mexp_pkg::ST_SQUARE;
        end else if (cur_bit) begin
          mul_start_o = 1'b1;
          mul_b_o     = base_q;
          state_d     = mexp_pkg::ST_MULT;
        end else begin
          // Leading zero bit: skip it.
          exp_d   = exp_q << 1;
          cnt_d   = cnt_q - CntW'(1);
          state_d = last_bit ? mexp_pkg::ST_DONE : mexp_pkg::ST_SCAN;
        end
      end
      mexp_pkg::ST_SQUARE: begin
        if (mul_stat_i.done) begin
          acc_d = mul_prod_i;
          if (cur_bit) begin
            mul_start_o = 1'b1;
            mul_a_o     = mul_prod_i;
            mul_b_o     = base_q;
            state_d     = mexp_pkg::ST_MULT;
          end else begin
            exp_d   = exp_q << 1;
            cnt_d   = cnt_q - CntW'(1);
            state_d = last_bit ? mexp_pkg::ST_DONE : mexp_pkg::ST_SCAN;
          end
        end
      end
      mexp_pkg::ST_MULT: begin
        if (mul_stat_i.done) begin
          acc_d     = mul_prod_i;
          started_d = 1'b1;
          exp_d     = exp_q << 1;
          cnt_d     = cnt_q - CntW'(1);
          state_d   = last_bit ? mexp_pkg::ST_DONE : mexp_pkg::ST_SCAN;
        end
      end
      mexp_pkg::ST_DONE: begin
        if (res_ready_i) begin
          state_d = mexp_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = mexp_pkg::ST_IDLE;
      end
    endcase
  end

  // State register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= mexp_pkg::ST_IDLE;
      started_q <= 1'b0;
      cnt_q     <= '0;
      err_q     <= 1'b0;
    end else begin
      state_q   <= state_d;
      started_q <= started_d;
      cnt_q     <= cnt_d;
      err_q     <= err_d;
    end
  end

  // Operand registers.
  always_ff @(posedge clk_i) begin
    base_q <= base_d;
    exp_q  <= exp_d;
    mod_q  <= mod_d;
    acc_q  <= acc_d;
  end

  assign ready_o     = (state_q == mexp_pkg::ST_IDLE);
  assign res_valid_o = (state_q == mexp_pkg::ST_DONE);
  assign res_o       = acc_q;
  assign err_o       = err_q;

endmodule

// ===== rtl/core/modular_exponentiation_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// modular_exponentiation_core: base^exponent mod modulus
// Left-to-right binary exponentiation over a single bit-serial modular
// multiplier, with an APB register for the modulus.
//
//   Channel   Direction  Payload
//   s_axis    in         tdata = base_value, exponent_value
//   m_axis    out        tdata = power_mod; tuser = error_flag
//   apb       in/out     modulus at byte address 0 (64 bits)
//
// From acceptance to output valid, an item runs these steps: the base
// reduction is one multiply, then each exponent bit past the leading one
// costs a squaring and, for a one bit, a multiply, each in the shared
// multiplier plus sequencing. Leading zero exponent bits are skipped
// without a multiply; a zero modulus answers without using the multiplier.
// s_axis_tready is low while an item is in progress; one finished result may
// wait in the output register while the next item is being worked on.
// Reset is asynchronous and active low; the modulus resets to 1.
// ----------------------------------------------------------------------------
module modular_exponentiation_core #(
  parameter int unsigned OPERAND_WIDTH = mexp_pkg::OPERAND_WIDTH_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // Input stream
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  // [63:0] base_value, [127:64] exponent_value
  input  logic [mexp_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
  // Output stream
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  // [63:0] power_mod
  output logic [mexp_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,
  // [0] error_flag
  output logic [mexp_pkg::OUT_TUSER_W-1:0]    m_axis_tuser,
  // Configuration
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [mexp_pkg::APB_ADDR_W-1:0]     paddr,
  input  logic [mexp_pkg::APB_DATA_W-1:0]     pwdata,
  output logic [mexp_pkg::APB_DATA_W-1:0]     prdata,
  output logic                                pready
);

  localparam int unsigned W  = OPERAND_WIDTH;
  localparam int unsigned DW = mexp_pkg::DATA_W;

  logic [DW-1:0]            modulus_q;
  logic                     reg_wr;
  logic                     in_accept;
  logic                     seq_ready;
  logic                     res_valid;
  logic                     res_ready;
  logic [W-1:0]             res_data;
  logic                     res_err;
  logic                     mul_start;
  logic [W-1:0]             mul_a;
  logic [W-1:0]             mul_b;
  logic [W-1:0]             mul_m;
  logic [W-1:0]             mul_prod;
  mexp_pkg::mexp_mul_stat_t mul_stat;
  logic                     out_valid_q;
  logic [DW-1:0]            out_data_q;
  logic                     out_err_q;

  // Register file: writes complete in the access phase.
  assign pready = 1'b1;
  assign reg_wr = psel && penable && pwrite && pready &&
                  (paddr[mexp_pkg::APB_ADDR_W-1] == mexp_pkg::REG_MODULUS);
  assign prdata = (paddr[mexp_pkg::APB_ADDR_W-1] == mexp_pkg::REG_MODULUS) ?
                  modulus_q : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      modulus_q <= DW'(1);
    end else if (reg_wr) begin
      modulus_q <= pwdata;
    end
  end

  // Input transaction.
  assign s_axis_tready = seq_ready;
  assign in_accept     = s_axis_tvalid && s_axis_tready;

  mexp_seq #(
    .OPERAND_WIDTH (OPERAND_WIDTH)
  ) u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (in_accept),
    .base_i      (s_axis_tdata[W-1:0]),
    .exp_i       (s_axis_tdata[DW+W-1:DW]),
    .mod_i       (modulus_q[W-1:0]),
    .ready_o     (seq_ready),
    .res_valid_o (res_valid),
    .res_ready_i (res_ready),
    .res_o       (res_data),
    .err_o       (res_err),
    .mul_start_o (mul_start),
    .mul_a_o     (mul_a),
    .mul_b_o     (mul_b),
    .mul_m_o     (mul_m),
    .mul_prod_i  (mul_prod),
    .mul_stat_i  (mul_stat)
  );

  mexp_modmul #(
    .OPERAND_WIDTH (OPERAND_WIDTH)
  ) u_modmul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mul_start),
    .a_i     (mul_a),
    .b_i     (mul_b),
    .m_i     (mul_m),
    .prod_o  (mul_prod),
    .stat_o  (mul_stat)
  );

  // Output register: loads when empty or being drained.
  assign res_ready = !out_valid_q || m_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_ready) begin
      out_valid_q <= res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_ready && res_valid) begin
      out_data_q <= DW'(res_data);
      out_err_q  <= res_err;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tuser  = out_err_q;

  // An error result carries zero data.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_err_q |-> out_data_q == '0)
    else $error("error result with nonzero data");

  // An accepted item makes the core busy in the next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_accept |=> !s_axis_tready)
    else $error("core still ready after accepting an item");

  // The multiplier is never started while it is running.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    mul_start |-> !mul_stat.busy)
    else $error("multiplier started while busy");

  // A new output transaction always comes from a finished sequencer result.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> $past(res_valid))
    else $error("output valid without a finished result");

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: self-checking testbench for modular_exponentiation_core
// Sets the modulus over APB and then streams base/exponent pairs into the
// core. A square-and-multiply model with 128-bit products predicts each
// power and error flag; every output transaction is compared with the oldest
// prediction. A directed table covers the zero, unit and all-ones cases.
// Random phases follow, each under its own modulus. Both stream sides idle
// at random, and one long receiver hold forces the core to stall its input.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int unsigned DATA_W      = mexp_pkg::DATA_W;
  localparam int unsigned IN_TDATA_W  = mexp_pkg::IN_TDATA_W;
  localparam int unsigned OUT_TDATA_W = mexp_pkg::OUT_TDATA_W;
  localparam int unsigned OUT_TUSER_W = mexp_pkg::OUT_TUSER_W;
  localparam int unsigned APB_ADDR_W  = mexp_pkg::APB_ADDR_W;
  localparam int unsigned APB_DATA_W  = mexp_pkg::APB_DATA_W;

  localparam int unsigned NUM_DIRECTED     = 20;
  localparam int unsigned NUM_PHASES       = 7;
  localparam int unsigned ITEMS_PER_PHASE  = 11;
  localparam int unsigned HOLD_AFTER       = 35;
  localparam int unsigned LONG_HOLD_CYCLES = 20000;
  localparam int unsigned CYCLE_LIMIT      = 5_000_000;
  localparam int unsigned MAX_REPORTS      = 10;
  localparam logic [APB_ADDR_W-1:0] MODULUS_ADDR = {mexp_pkg::REG_MODULUS, 3'b000};
  localparam logic [DATA_W-1:0] ALL_ONES = {DATA_W{1'b1}};
  localparam logic [DATA_W-1:0] TOP_BIT  = {1'b1, {(DATA_W-1){1'b0}}};
  localparam logic [DATA_W-1:0] PRIME_64 = 64'hFFFF_FFFF_FFFF_FFC5;

  // One predicted output transaction.
  typedef struct packed {
    logic [DATA_W-1:0] power;
    logic              err;
  } power_result_t;

  // One row of the directed table; known rows carry a hand-written answer.
  typedef struct {
    bit                set_mod;
    logic [DATA_W-1:0] mod_val;
    logic [DATA_W-1:0] base;
    logic [DATA_W-1:0] expo;
    bit                known;
    logic [DATA_W-1:0] power;
    bit                err;
  } stim_row_t;

  logic                   clk_i = 1'b0;
  logic                   rst_ni;
  logic                   s_axis_tvalid;
  logic                   s_axis_tready;
  logic [IN_TDATA_W-1:0]  s_axis_tdata;   // [63:0] base_value, [127:64] exponent_value
  logic                   m_axis_tvalid;
  logic                   m_axis_tready;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;   // [63:0] power_mod
  logic [OUT_TUSER_W-1:0] m_axis_tuser;   // [0] error_flag
  logic                   psel;
  logic                   penable;
  logic                   pwrite;
  logic [APB_ADDR_W-1:0]  paddr;
  logic [APB_DATA_W-1:0]  pwdata;
  logic [APB_DATA_W-1:0]  prdata;
  logic                   pready;

  power_result_t     pending_powers[$];
  power_result_t     oldest_power;
  logic [DATA_W-1:0] active_modulus;
  int unsigned       mismatch_count = 0;
  int unsigned       results_seen = 0;
  int unsigned       cycle_count = 0;
  bit                long_hold_done = 1'b0;
  stim_row_t         directed_rows [NUM_DIRECTED];

  modular_exponentiation_core i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  // Clock with a 20 ns period.
  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // Timeout guard.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("[modular_exponentiation_core] ERROR");
      $finish;
    end
  end

  // The product is formed at full 128-bit width and then reduced.
  function automatic logic [DATA_W-1:0] mul_reduce(input logic [DATA_W-1:0] a,
                                                   input logic [DATA_W-1:0] b,
                                                   input logic [DATA_W-1:0] m);
    logic [2*DATA_W-1:0] prod;
    prod = {{DATA_W{1'b0}}, a} * {{DATA_W{1'b0}}, b};
    return DATA_W'(prod % {{DATA_W{1'b0}}, m});
  endfunction

  // Right-to-left square-and-multiply; it gives the same power as the
  // core's left-to-right scan.
  function automatic power_result_t predict_power(input logic [DATA_W-1:0] base,
                                                  input logic [DATA_W-1:0] expo,
                                                  input logic [DATA_W-1:0] m);
    power_result_t     res;
    logic [DATA_W-1:0] sq;
    logic [DATA_W-1:0] acc;
    if (m == '0) begin
      res.power = '0;
      res.err   = 1'b1;
      return res;
    end
    sq  = base % m;
    acc = (m == DATA_W'(1)) ? '0 : DATA_W'(1);
    for (int i = 0; i < DATA_W; i++) begin
      if (expo[i]) begin
        acc = mul_reduce(acc, sq, m);
      end
      sq = mul_reduce(sq, sq, m);
    end
    res.power = acc;
    res.err   = 1'b0;
    return res;
  endfunction

  // Gap lengths: mostly none or short, a few long.
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 20);
    return $urandom_range(50, 300);
  endfunction

  function automatic logic [DATA_W-1:0] pick_modulus(input int unsigned phase);
    case (phase)
      0: return {$urandom | 32'h8000_0000, $urandom};
      1: return DATA_W'($urandom_range(2, 300));
      2: return '0;
      3: return ALL_ONES;
      4: return DATA_W'(1) << $urandom_range(1, DATA_W - 1);
      5: return {$urandom, $urandom} | DATA_W'(1);
      default: return DATA_W'(3);
    endcase
  endfunction

  function automatic logic [DATA_W-1:0] pick_base();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 10) return '0;
    if (r < 20) return ALL_ONES;
    if (r < 35) return DATA_W'($urandom_range(0, 1000));
    return {$urandom, $urandom};
  endfunction

  // Exponents are mostly short to keep the run brief; a few use all 64 bits.
  function automatic logic [DATA_W-1:0] pick_exponent();
    int unsigned       r;
    logic [DATA_W-1:0] mask;
    r = $urandom_range(0, 99);
    if (r < 10) return {$urandom, $urandom};
    if (r < 15) return '0;
    if (r < 20) return DATA_W'(1);
    mask = (DATA_W'(1) << $urandom_range(1, 12)) - DATA_W'(1);
    return {$urandom, $urandom} & mask;
  endfunction

  task automatic note_mismatch(input string what, input logic [DATA_W-1:0] want,
                               input logic [DATA_W-1:0] got);
    if (mismatch_count < MAX_REPORTS) begin
      $display("mismatch in %s: expected %h, got %h", what, want, got);
    end
    mismatch_count++;
  endtask

  // Writes the modulus, then reads it back. Called at a falling edge.
  task automatic program_modulus(input logic [DATA_W-1:0] value);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b1;
    paddr   = MODULUS_ADDR;
    pwdata  = value;
    @(negedge clk_i);
    penable = 1'b1;
    do @(posedge clk_i); while (!pready);
    active_modulus = value;
    @(negedge clk_i);
    pwrite  = 1'b0;
    penable = 1'b0;
    @(negedge clk_i);
    penable = 1'b1;
    do @(posedge clk_i); while (!pready);
    if (prdata !== value) note_mismatch("modulus readback", value, prdata);
    @(negedge clk_i);
    psel    = 1'b0;
    penable = 1'b0;
  endtask

  // Lets the core run dry before the modulus changes.
  task automatic wait_idle();
    s_axis_tvalid = 1'b0;
    while (pending_powers.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  // Offers one base/exponent pair and records its expected result once the
  // transaction is accepted. Entered and left at a falling edge.
  task automatic send_item(input logic [DATA_W-1:0] base, input logic [DATA_W-1:0] expo,
                           input bit allow_gap, input bit known,
                           input power_result_t typed);
    int unsigned gap;
    gap = allow_gap ? pick_gap() : 0;
    if (gap > 0) begin
      s_axis_tvalid = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tdata  = {expo, base};
    s_axis_tvalid = 1'b1;
    do @(posedge clk_i); while (!s_axis_tready);
    pending_powers.push_back(known ? typed : predict_power(base, expo, active_modulus));
    @(negedge clk_i);
  endtask

  // Output checker.
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      results_seen++;
      if (pending_powers.size() == 0) begin
        note_mismatch("unexpected result", '0, m_axis_tdata);
      end else begin
        oldest_power = pending_powers.pop_front();
        if (m_axis_tdata !== oldest_power.power) begin
          note_mismatch("power_mod", oldest_power.power, m_axis_tdata);
        end
        if (m_axis_tuser[0] !== oldest_power.err) begin
          note_mismatch("error_flag", DATA_W'(oldest_power.err), DATA_W'(m_axis_tuser[0]));
        end
      end
    end
  end

  // Result receiver with random stalls and one long hold.
  initial begin : result_sink
    int unsigned run;
    int unsigned stall;
    bit          hold_now;
    m_axis_tready = 1'b0;
    @(posedge rst_ni);
    forever begin
      hold_now = 1'b0;
      run = ($urandom_range(0, 9) == 0) ? $urandom_range(200, 3000) : $urandom_range(1, 40);
      m_axis_tready = 1'b1;
      repeat (run) begin
        @(negedge clk_i);
        if (!long_hold_done && results_seen >= HOLD_AFTER) begin
          hold_now = 1'b1;
          break;
        end
      end
      stall = hold_now ? LONG_HOLD_CYCLES : pick_gap();
      if (hold_now) long_hold_done = 1'b1;
      if (stall > 0) begin
        m_axis_tready = 1'b0;
        repeat (stall) @(negedge clk_i);
      end
    end
  end

  // Stimulus.
  initial begin : stimulus
    power_result_t     typed;
    logic [DATA_W-1:0] new_mod;
    bit                steady;

    rst_ni         = 1'b0;
    s_axis_tvalid  = 1'b0;
    s_axis_tdata   = '0;
    psel           = 1'b0;
    penable        = 1'b0;
    pwrite         = 1'b0;
    paddr          = '0;
    pwdata         = '0;
    active_modulus = DATA_W'(1);

    // set_mod, mod_val, base, expo, known, power, err
    directed_rows = '{
      // Modulus of one after reset.
      '{0, 64'd0, 64'd5, 64'd3, 1, 64'd0, 0},
      '{0, 64'd0, ALL_ONES, ALL_ONES, 1, 64'd0, 0},
      // Zero modulus raises the error flag.
      '{1, 64'd0, 64'd7, 64'd2, 1, 64'd0, 1},
      '{0, 64'd0, ALL_ONES, ALL_ONES, 1, 64'd0, 1},
      '{0, 64'd0, 64'd0, 64'd0, 1, 64'd0, 1},
      // All-ones modulus: zero exponent, zero base, base equal to the modulus.
      '{1, ALL_ONES, 64'd0, 64'd0, 1, 64'd1, 0},
      '{0, 64'd0, 64'd0, 64'd5, 1, 64'd0, 0},
      '{0, 64'd0, ALL_ONES, 64'd1, 1, 64'd0, 0},
      '{0, 64'd0, 64'd2, 64'd63, 1, TOP_BIT, 0},
      '{0, 64'd0, 64'd2, 64'd64, 1, 64'd1, 0},
      '{0, 64'd0, ALL_ONES - 64'd1, ALL_ONES, 0, 64'd0, 0},
      // Largest 64-bit prime.
      '{1, PRIME_64, 64'd3, PRIME_64 - 64'd2, 0, 64'd0, 0},
      '{0, 64'd0, 64'd12345, 64'd0, 1, 64'd1, 0},
      '{0, 64'd0, ALL_ONES, TOP_BIT, 0, 64'd0, 0},
      // Modulus of two.
      '{1, 64'd2, 64'd3, ALL_ONES, 1, 64'd1, 0},
      '{0, 64'd0, 64'd4, 64'd7, 1, 64'd0, 0},
      '{1, TOP_BIT, 64'd3, TOP_BIT, 0, 64'd0, 0},
      '{0, 64'd0, 64'd0, 64'd1, 1, 64'd0, 0},
      '{1, 64'd97, 64'd1000, 64'd1000, 0, 64'd0, 0},
      '{0, 64'd0, 64'hAAAA_AAAA_5555_5555, 64'h5555_5555_AAAA_AAAA, 0, 64'd0, 0}
    };

    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Directed table.
    foreach (directed_rows[i]) begin
      if (directed_rows[i].set_mod) begin
        wait_idle();
        program_modulus(directed_rows[i].mod_val);
      end
      typed.power = directed_rows[i].power;
      typed.err   = directed_rows[i].err;
      send_item(directed_rows[i].base, directed_rows[i].expo, 1'b1,
                directed_rows[i].known, typed);
    end

    // Random phases, each under a fresh modulus.
    typed = '0;
    for (int unsigned p = 0; p < NUM_PHASES; p++) begin
      new_mod = pick_modulus(p);
      steady  = ($urandom_range(0, 3) == 0);
      wait_idle();
      program_modulus(new_mod);
      for (int unsigned n = 0; n < ITEMS_PER_PHASE; n++) begin
        send_item(pick_base(), pick_exponent(), !steady, 1'b0, typed);
      end
    end

    // Drain and look for stray results.
    s_axis_tvalid = 1'b0;
    while (pending_powers.size() != 0) @(posedge clk_i);
    repeat (200) @(posedge clk_i);

    if (mismatch_count == 0) begin
      $display("[modular_exponentiation_core] OK");
    end else begin
      $display("[modular_exponentiation_core] ERROR");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/core/mexp_pkg.sv
rtl/core/mexp_modmul.sv
rtl/core/mexp_seq.sv
rtl/core/modular_exponentiation_core.sv
tb/tb_top.sv
